// ----- sv/dnle_pkg.sv -----
// shared types and constants for the dns name label encoder
// no dependencies
`default_nettype none
package dnle_pkg;

	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned CAP_W       = 10;
	localparam int unsigned CNT_W       = 10;
	localparam int unsigned LBL_CNT_W   = 6;
	localparam int unsigned STORE_DEPTH = 64;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned LABEL_MAX_DEF = 61;

	localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
	localparam logic [CHAR_W-1:0] TERM_BYTE = 8'h00;
	localparam logic [CNT_W-1:0]  COUNT_MAX = 10'd1023;
	localparam logic [CAP_W-1:0]  CAP_RESET = 10'd128;

	// one result byte on its way to the output register
	typedef struct packed {
		logic [CHAR_W-1:0] out_byte;
		logic              is_last_byte;
		logic              encode_error;
	} dnle_item_t;

endpackage
`default_nettype wire

// ----- sv/dns_name_label_encoder.sv -----
// top level: dotted name in, dns label encoding out
// depends on dnle_pkg, dnle_label_mem, dnle_out_reg
//
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   name_char, is_last_char
// output    out        out_valid / out_stall out_byte, is_last_byte, encode_error
// config    in         cfg_wen               cfg_wdata (name_capacity)
//
// a character that only buffers leaves the block idle; it takes the next one right after.
// a character that closes a label stalls input while the length byte, the label bytes and any
// terminator bytes go out; the label store gives one byte per cycle to the output register
// while not stalled. an error result goes out from the error state. a stalled output holds the sequencer in place.
// reset is immediate: no clearing pass, only label store entries that were written are sent.
`default_nettype none
module dns_name_label_encoder #(
	parameter int unsigned LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [dnle_pkg::CAP_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [dnle_pkg::CHAR_W-1:0]   name_char,
	input  wire logic                          is_last_char,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [dnle_pkg::CHAR_W-1:0]   out_byte,
	output logic                               is_last_byte,
	output logic                               encode_error
);
	import dnle_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LEN   = 3'd1;
	localparam logic [2:0] ST_BYTES = 3'd2;
	localparam logic [2:0] ST_ZLEN  = 3'd3;
	localparam logic [2:0] ST_TERM  = 3'd4;
	localparam logic [2:0] ST_ERR   = 3'd5;

	localparam logic [LBL_CNT_W-1:0] LBL_LIMIT = LBL_CNT_W'(LABEL_MAX);

	logic [2:0]           state_q;
	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LBL_CNT_W-1:0] lbl_cnt_q;
	logic [LBL_CNT_W-1:0] flush_len_q;
	logic [ADDR_W-1:0]    rd_idx_q;
	logic                 discard_q;
	logic                 zlen_q;
	logic                 term_q;

	logic                 accept;
	logic [CNT_W-1:0]     cnt_next;
	logic                 err_cap;
	logic                 err_lbl;
	logic                 is_dot;
	logic                 mem_wen;
	logic [ADDR_W-1:0]    rd_addr;
	logic [CHAR_W-1:0]    rd_data;
	logic                 out_free;
	logic                 load;
	logic                 bytes_done;
	logic [2:0]           after_flush;
	dnle_item_t           item;
	dnle_item_t           out_item;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign cnt_next = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign err_cap  = {cnt_next, 1'b0} > {1'b0, cap_q};
	assign is_dot   = (name_char == DOT_CHAR);
	assign err_lbl  = !is_dot && (lbl_cnt_q >= LBL_LIMIT);
	assign mem_wen  = accept && !discard_q && !err_cap && !err_lbl && !is_dot;

	assign load       = out_free && (state_q != ST_IDLE);
	assign bytes_done = (rd_idx_q + 1'b1) == flush_len_q;
	assign after_flush = zlen_q ? ST_ZLEN : (term_q ? ST_TERM : ST_IDLE);

	// look one entry ahead when a label byte leaves, so read data keeps up
	assign rd_addr = (state_q == ST_BYTES && load) ? rd_idx_q + 1'b1 : rd_idx_q;

	always_comb begin
		item = '0;
		unique case (state_q)
			ST_LEN:   item.out_byte = CHAR_W'(flush_len_q);
			ST_BYTES: item.out_byte = rd_data;
			ST_TERM: begin
				item.out_byte     = TERM_BYTE;
				item.is_last_byte = 1'b1;
			end
			ST_ERR: begin
				item.is_last_byte = 1'b1;
				item.encode_error = 1'b1;
			end
			default: item = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wen) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lbl_cnt_q   <= '0;
			flush_len_q <= '0;
			rd_idx_q    <= '0;
			discard_q   <= 1'b0;
			zlen_q      <= 1'b0;
			term_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						if (discard_q) begin
							if (is_last_char) begin
								cnt_q     <= '0;
								lbl_cnt_q <= '0;
								discard_q <= 1'b0;
							end
						end else if (err_cap || err_lbl) begin
							state_q <= ST_ERR;
							if (is_last_char) begin
								cnt_q     <= '0;
								lbl_cnt_q <= '0;
							end else begin
								cnt_q     <= cnt_next;
								discard_q <= 1'b1;
							end
						end else if (is_dot) begin
							state_q     <= ST_LEN;
							flush_len_q <= lbl_cnt_q;
							lbl_cnt_q   <= '0;
							zlen_q      <= is_last_char;
							term_q      <= is_last_char;
							cnt_q       <= is_last_char ? '0 : cnt_next;
						end else if (is_last_char) begin
							state_q     <= ST_LEN;
							flush_len_q <= lbl_cnt_q + 1'b1;
							lbl_cnt_q   <= '0;
							zlen_q      <= 1'b0;
							term_q      <= 1'b1;
							cnt_q       <= '0;
						end else begin
							lbl_cnt_q <= lbl_cnt_q + 1'b1;
							cnt_q     <= cnt_next;
						end
					end
				end
				ST_LEN: begin
					if (load) begin
						state_q <= (flush_len_q == '0) ? after_flush : ST_BYTES;
					end
				end
				ST_BYTES: begin
					if (load) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (bytes_done) begin
							state_q <= after_flush;
						end
					end
				end
				ST_ZLEN: begin
					if (load) begin
						state_q <= ST_TERM;
						zlen_q  <= 1'b0;
					end
				end
				ST_TERM: begin
					if (load) begin
						state_q <= ST_IDLE;
						term_q  <= 1'b0;
					end
				end
				ST_ERR: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	dnle_label_mem #(
		.DEPTH (STORE_DEPTH)
	) u_mem (
		.clk   (clk),
		.wen   (mem_wen),
		.waddr (lbl_cnt_q),
		.wdata (name_char),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	dnle_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.item      (item),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign out_byte     = out_item.out_byte;
	assign is_last_byte = out_item.is_last_byte;
	assign encode_error = out_item.encode_error;

	// label read index never runs past the label being flushed
	a_idx_in_label: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BYTES) |-> (rd_idx_q < flush_len_q))
		else $error("label read index past label length");

	// buffered label never grows past the limit
	a_lbl_limit: assert property (@(posedge clk) disable iff (!arst_n)
		lbl_cnt_q <= LBL_LIMIT)
		else $error("label count above limit");

	// while dropping a name only the error result may be pending
	a_discard_err: assert property (@(posedge clk) disable iff (!arst_n)
		(discard_q && state_q != ST_IDLE) |-> (state_q == ST_ERR))
		else $error("flush in progress while discarding");

	// terminator leaves as the last byte of the name
	a_term_out: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_TERM) |=> (out_valid && is_last_byte && !encode_error))
		else $error("terminator transaction malformed");

endmodule
`default_nettype wire

// ----- sv/dnle_label_mem.sv -----
// label byte store: one write port, one read port with registered data
// depends on dnle_pkg
`default_nettype none
module dnle_label_mem #(
	parameter int unsigned DEPTH = dnle_pkg::STORE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             wen,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [dnle_pkg::CHAR_W-1:0]      wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [dnle_pkg::CHAR_W-1:0]      rdata
);
	import dnle_pkg::*;

	logic [CHAR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/dnle_out_reg.sv -----
// output register for result transactions, frees itself when taken
// depends on dnle_pkg
`default_nettype none
module dnle_out_reg (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire dnle_pkg::dnle_item_t    item,
	output logic                         free,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output dnle_pkg::dnle_item_t         out_item
);
	import dnle_pkg::*;

	logic       valid_q;
	dnle_item_t item_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

endmodule
`default_nettype wire
